@@ src/vipdf_pkg.sv @@
// ----------------------------------------------------------------------------
// vipdf_pkg
// shared constants and types for the vlan / ipv4 protocol drop filter
// ----------------------------------------------------------------------------
package vipdf_pkg;

  localparam int MAX_VLAN_TAGS = 2;

  localparam int OFF_W      = 7;
  localparam int ETYPE_W    = 16;
  localparam int HL_W       = 6;
  localparam int PROTO_W    = 8;
  localparam int TOTAL_W    = OFF_W + 1;
  localparam int TAG_CNT_W  = $clog2(MAX_VLAN_TAGS + 2);

  localparam int ETH_HDR_LEN  = 14;
  localparam int TAG_LEN      = 4;
  localparam int IPV4_MIN_HDR = 20;
  localparam int IP_START_W   = $clog2(ETH_HDR_LEN + TAG_LEN * MAX_VLAN_TAGS + 1);

  localparam logic [OFF_W-1:0]   OFFSET_MAX   = '1;
  localparam logic [OFF_W-1:0]   OFF_ETYPE_HI = OFF_W'(12);
  localparam logic [OFF_W-1:0]   OFF_ETYPE_LO = OFF_W'(13);
  localparam logic [OFF_W-1:0]   REL_TAG_HI   = OFF_W'(2);
  localparam logic [OFF_W-1:0]   REL_TAG_LO   = OFF_W'(3);
  localparam logic [OFF_W-1:0]   REL_IHL      = OFF_W'(0);
  localparam logic [OFF_W-1:0]   REL_PROTO    = OFF_W'(9);

  localparam logic [ETYPE_W-1:0] ETYPE_CTAG   = 16'h8100;
  localparam logic [ETYPE_W-1:0] ETYPE_STAG   = 16'h88A8;
  localparam logic [ETYPE_W-1:0] ETH_P_IP     = 16'h0800;
  localparam logic [PROTO_W-1:0] PROTO_TCP    = 8'd6;

  localparam int               CFG_ADDR_W   = 3;
  localparam int               CFG_DATA_W   = 32;
  localparam logic             REG_DROP_PROTO = 1'b0;

  typedef enum logic [3:0] {
    PH_ETH   = 4'b0001,
    PH_TAG   = 4'b0010,
    PH_IP    = 4'b0100,
    PH_OTHER = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    R_MATCH    = 3'd0,
    R_OTHER    = 3'd1,
    R_NOT_IPV4 = 3'd2,
    R_TRUNC    = 3'd3,
    R_BAD_HL   = 3'd4
  } reason_t;

endpackage

@@ src/vlan_ipv4_protocol_drop_filter_unit.sv @@
// ----------------------------------------------------------------------------
// vlan_ipv4_protocol_drop_filter_unit
// per-byte ethernet / vlan / ipv4 header parser with protocol drop verdict
// ----------------------------------------------------------------------------
// verdict is registered and appears in the cycle after the end-marked beat is accepted
// throughput: one byte beat per cycle while in_ready is high, set by the single parse stage
// an output register holds the verdict; while it waits in_ready stays low
// reset: synchronous active-low rst_n clears parse state, drop_protocol = 6
module vlan_ipv4_protocol_drop_filter_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             in_frame_byte,
  input  logic                                   in_frame_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_drop,
  output logic [2:0]                             out_verdict_reason,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [vipdf_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [vipdf_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [vipdf_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                   pready
);

  logic [vipdf_pkg::PROTO_W-1:0]    drop_proto_r;
  logic [vipdf_pkg::OFF_W-1:0]      off_r, off_nxt;
  logic [vipdf_pkg::ETYPE_W-1:0]    etype_r, etype_nxt;
  logic [vipdf_pkg::TAG_CNT_W-1:0]  tags_r, tags_nxt;
  logic [vipdf_pkg::IP_START_W-1:0] ip_start_r, ip_start_nxt;
  logic [vipdf_pkg::HL_W-1:0]       hl_r, hl_nxt;
  logic [vipdf_pkg::PROTO_W-1:0]    proto_r, proto_nxt;
  vipdf_pkg::phase_t                phase_r, phase_nxt;

  logic                             out_valid_r;
  logic                             drop_r, drop_nxt;
  vipdf_pkg::reason_t               reason_r, reason_nxt;

  logic                             in_fire;
  logic                             cfg_wr;
  logic [vipdf_pkg::OFF_W-1:0]      ip_start_ext;
  logic [vipdf_pkg::OFF_W-1:0]      rel;
  logic [vipdf_pkg::TOTAL_W-1:0]    total;
  logic [vipdf_pkg::TOTAL_W-1:0]    start_ext;
  logic [vipdf_pkg::TOTAL_W-1:0]    have;

  function automatic vipdf_pkg::phase_t after_etype(
    input logic [vipdf_pkg::ETYPE_W-1:0]   et,
    input logic [vipdf_pkg::TAG_CNT_W-1:0] tags
  );
    logic is_vlan;
    is_vlan = (et == vipdf_pkg::ETYPE_CTAG) || (et == vipdf_pkg::ETYPE_STAG);
    if (is_vlan && (tags < vipdf_pkg::TAG_CNT_W'(vipdf_pkg::MAX_VLAN_TAGS))) begin
      return vipdf_pkg::PH_TAG;
    end else if (et == vipdf_pkg::ETH_P_IP) begin
      return vipdf_pkg::PH_IP;
    end else begin
      return vipdf_pkg::PH_OTHER;
    end
  endfunction

  // handshakes
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_drop  = drop_r;
  assign out_verdict_reason = reason_r;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[vipdf_pkg::CFG_ADDR_W-1] == vipdf_pkg::REG_DROP_PROTO);
  always_comb begin
    prdata = '0;
    if (paddr[vipdf_pkg::CFG_ADDR_W-1] == vipdf_pkg::REG_DROP_PROTO) begin
      prdata = vipdf_pkg::CFG_DATA_W'(drop_proto_r);
    end
  end

  // parse step
  assign ip_start_ext = vipdf_pkg::OFF_W'(ip_start_r);
  assign rel = (off_r >= ip_start_ext) ? (off_r - ip_start_ext) : '0;

  always_comb begin
    etype_nxt    = etype_r;
    tags_nxt     = tags_r;
    ip_start_nxt = ip_start_r;
    hl_nxt       = hl_r;
    proto_nxt    = proto_r;
    phase_nxt    = phase_r;
    unique case (phase_r)
      vipdf_pkg::PH_ETH: begin
        if (off_r == vipdf_pkg::OFF_ETYPE_HI) begin
          etype_nxt = {in_frame_byte, 8'h00};
        end else if (off_r == vipdf_pkg::OFF_ETYPE_LO) begin
          etype_nxt = {etype_r[15:8], in_frame_byte};
          phase_nxt = after_etype(etype_nxt, tags_r);
        end
      end
      vipdf_pkg::PH_TAG: begin
        if (rel == vipdf_pkg::REL_TAG_HI) begin
          etype_nxt = {in_frame_byte, etype_r[7:0]};
        end else if (rel == vipdf_pkg::REL_TAG_LO) begin
          etype_nxt    = {etype_r[15:8], in_frame_byte};
          tags_nxt     = tags_r + 1'b1;
          ip_start_nxt = ip_start_r + vipdf_pkg::IP_START_W'(vipdf_pkg::TAG_LEN);
          phase_nxt    = after_etype(etype_nxt, tags_nxt);
        end
      end
      vipdf_pkg::PH_IP: begin
        if (rel == vipdf_pkg::REL_IHL) begin
          hl_nxt = {in_frame_byte[3:0], 2'b00};
        end else if (rel == vipdf_pkg::REL_PROTO) begin
          proto_nxt = in_frame_byte;
        end
      end
      vipdf_pkg::PH_OTHER: begin
      end
      default: begin
      end
    endcase
  end

  assign off_nxt   = (off_r < vipdf_pkg::OFFSET_MAX) ? off_r + 1'b1 : off_r;
  assign total     = {1'b0, off_r} + 1'b1;
  assign start_ext = vipdf_pkg::TOTAL_W'(ip_start_nxt);
  assign have      = (total >= start_ext) ? (total - start_ext) : '0;

  // verdict
  always_comb begin
    drop_nxt   = 1'b0;
    reason_nxt = vipdf_pkg::R_NOT_IPV4;
    priority if (phase_nxt == vipdf_pkg::PH_ETH) begin
      reason_nxt = vipdf_pkg::R_TRUNC;
    end else if (phase_nxt == vipdf_pkg::PH_IP) begin
      priority if (have < vipdf_pkg::TOTAL_W'(vipdf_pkg::IPV4_MIN_HDR)) begin
        reason_nxt = vipdf_pkg::R_TRUNC;
      end else if (hl_nxt < vipdf_pkg::HL_W'(vipdf_pkg::IPV4_MIN_HDR)) begin
        reason_nxt = vipdf_pkg::R_BAD_HL;
      end else if (have < vipdf_pkg::TOTAL_W'(hl_nxt)) begin
        reason_nxt = vipdf_pkg::R_TRUNC;
      end else if (proto_nxt == drop_proto_r) begin
        drop_nxt   = 1'b1;
        reason_nxt = vipdf_pkg::R_MATCH;
      end else begin
        reason_nxt = vipdf_pkg::R_OTHER;
      end
    end else begin
      reason_nxt = vipdf_pkg::R_NOT_IPV4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_proto_r <= vipdf_pkg::PROTO_TCP;
    end else if (cfg_wr) begin
      drop_proto_r <= pwdata[vipdf_pkg::PROTO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r      <= '0;
      etype_r    <= '0;
      tags_r     <= '0;
      ip_start_r <= vipdf_pkg::IP_START_W'(vipdf_pkg::ETH_HDR_LEN);
      hl_r       <= '0;
      proto_r    <= '0;
      phase_r    <= vipdf_pkg::PH_ETH;
    end else if (in_fire) begin
      if (in_frame_end) begin
        off_r      <= '0;
        etype_r    <= '0;
        tags_r     <= '0;
        ip_start_r <= vipdf_pkg::IP_START_W'(vipdf_pkg::ETH_HDR_LEN);
        hl_r       <= '0;
        proto_r    <= '0;
        phase_r    <= vipdf_pkg::PH_ETH;
      end else begin
        off_r      <= off_nxt;
        etype_r    <= etype_nxt;
        tags_r     <= tags_nxt;
        ip_start_r <= ip_start_nxt;
        hl_r       <= hl_nxt;
        proto_r    <= proto_nxt;
        phase_r    <= phase_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_frame_end) begin
      drop_r   <= drop_nxt;
      reason_r <= reason_nxt;
    end
  end

endmodule
